FILE: sv/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character codes and classification helpers for the
// infix-to-postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam logic [7:0] CH_PLUS   = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // '-'
  localparam logic [7:0] CH_STAR   = 8'h2A;  // '*'
  localparam logic [7:0] CH_SLASH  = 8'h2F;  // '/'
  localparam logic [7:0] CH_CARET  = 8'h5E;  // '^'
  localparam logic [7:0] CH_LPAR   = 8'h28;  // '('
  localparam logic [7:0] CH_RPAR   = 8'h29;  // ')'
  localparam logic [7:0] CH_SPACE  = 8'h20;  // ' '
  localparam logic [7:0] CH_LOW_A  = 8'd97;
  localparam logic [7:0] CH_LOW_Z  = 8'd122;
  localparam logic [7:0] CH_NUL    = 8'h00;

  // rank offset by one so that it fits an unsigned code: -1 -> 0 ... 2 -> 3
  localparam logic [1:0] RANK_NONE  = 2'd0;
  localparam logic [1:0] RANK_CARET = 2'd1;
  localparam logic [1:0] RANK_ADD   = 2'd2;
  localparam logic [1:0] RANK_MUL   = 2'd3;

  typedef enum logic [2:0] {
    KIND_LETTER,
    KIND_LPAR,
    KIND_RPAR,
    KIND_SPACE,
    KIND_OP,
    KIND_EOL
  } kind_t;

  typedef struct packed {
    logic latch;      // capture the incoming word
    logic push_in;    // push the incoming '('
    logic push_op;    // push the held operator
    logic pop;        // drop the top entry
    logic emit_top;   // send the top entry out
    logic emit_char;  // send the held letter out
    logic emit_term;  // send the terminator out
    logic top_last;   // last flag for emit_top
    logic err_extra;  // error that the current word will raise
    logic set_err;
    logic clear_eol;
  } cmd_t;

  typedef struct packed {
    kind_t in_kind;
    kind_t kind;
    logic  count_zero;
    logic  count_one;
    logic  top_lpar;
    logic  below_lpar;
    logic  stop_top;    // held operator must not pop the top
    logic  stop_below;  // held operator must not pop the entry below top
    logic  open_zero;   // no '(' on the stack
    logic  out_free;
  } sts_t;

  function automatic logic [1:0] rank_of(input logic [7:0] ch);
    logic [1:0] r;
    unique case (ch)
      CH_PLUS, CH_MINUS: r = RANK_ADD;
      CH_STAR, CH_SLASH: r = RANK_MUL;
      CH_CARET:          r = RANK_CARET;
      default:           r = RANK_NONE;
    endcase
    return r;
  endfunction

  function automatic kind_t classify(input logic [7:0] ch, input logic eol);
    kind_t k;
    priority if (eol) begin
      k = KIND_EOL;
    end else if (ch >= CH_LOW_A && ch <= CH_LOW_Z) begin
      k = KIND_LETTER;
    end else if (ch == CH_LPAR) begin
      k = KIND_LPAR;
    end else if (ch == CH_RPAR) begin
      k = KIND_RPAR;
    end else if (ch == CH_SPACE) begin
      k = KIND_SPACE;
    end else begin
      k = KIND_OP;
    end
    return k;
  endfunction

endpackage

FILE: sv/i2p_ram.sv
// ----------------------------------------------------------------------------
// i2p_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module i2p_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

FILE: sv/i2p_dpath.sv
// ----------------------------------------------------------------------------
// i2p_dpath
// Operator stack, counters, sticky error and the output register.
// ----------------------------------------------------------------------------
module i2p_dpath #(
  parameter int STACK_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [7:0]    in_char,
  input  logic          end_of_line,
  input  i2p_pkg::cmd_t cmd,
  output i2p_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          is_terminator,
  output logic          last_of_run,
  output logic          error_flag
);
  import i2p_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] open_count;
  logic          error_seen;
  logic [7:0]    cur_char;
  kind_t         cur_kind;

  logic [CW-1:0] top_pos;
  logic [CW-1:0] below_pos;
  logic [7:0]    top_data;
  logic [7:0]    below_data;
  logic          full;
  logic          push;
  logic          do_write;
  logic [1:0]    cur_rank;
  logic          out_free;

  assign top_pos   = count - CW'(1);
  assign below_pos = count - CW'(2);
  assign full      = (count == CW'(STACK_DEPTH));
  assign push      = cmd.push_in | cmd.push_op;
  assign do_write  = push & ~full;
  assign cur_rank  = rank_of(cur_char);
  assign out_free  = ~out_valid | out_ready;

  i2p_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (do_write),
    .waddr   (count[AW-1:0]),
    .wdata   (cmd.push_in ? in_char : cur_char),
    .raddr_a (top_pos[AW-1:0]),
    .rdata_a (top_data),
    .raddr_b (below_pos[AW-1:0]),
    .rdata_b (below_data)
  );

  always_comb begin
    sts.in_kind    = classify(in_char, end_of_line);
    sts.kind       = cur_kind;
    sts.count_zero = (count == '0);
    sts.count_one  = (count == CW'(1));
    sts.top_lpar   = (top_data == CH_LPAR);
    sts.below_lpar = (below_data == CH_LPAR);
    sts.stop_top   = (top_data == CH_LPAR) || (cur_rank > rank_of(top_data));
    sts.stop_below = (below_data == CH_LPAR) || (cur_rank > rank_of(below_data));
    sts.open_zero  = (open_count == '0);
    sts.out_free   = out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      open_count <= '0;
      error_seen <= 1'b0;
      out_valid  <= 1'b0;
      cur_kind   <= KIND_SPACE;
    end else begin
      if (cmd.latch) begin
        cur_kind <= sts.in_kind;
      end

      priority if (cmd.clear_eol) begin
        count <= '0;
      end else if (cmd.pop) begin
        count <= count - CW'(1);
      end else if (do_write) begin
        count <= count + CW'(1);
      end else begin
        count <= count;
      end

      priority if (cmd.clear_eol) begin
        open_count <= '0;
      end else if (cmd.pop && sts.top_lpar) begin
        open_count <= open_count - CW'(1);
      end else if (do_write && cmd.push_in) begin
        open_count <= open_count + CW'(1);
      end else begin
        open_count <= open_count;
      end

      // overflow: drop the push, flag it
      priority if (cmd.clear_eol) begin
        error_seen <= 1'b0;
      end else if (cmd.set_err || (push && full)) begin
        error_seen <= 1'b1;
      end else begin
        error_seen <= error_seen;
      end

      if (cmd.emit_top || cmd.emit_char || cmd.emit_term) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cur_char <= in_char;
    end
    priority if (cmd.emit_top) begin
      out_char      <= top_data;
      is_terminator <= 1'b0;
      last_of_run   <= cmd.top_last;
      error_flag    <= error_seen | cmd.err_extra;
    end else if (cmd.emit_char) begin
      out_char      <= cur_char;
      is_terminator <= 1'b0;
      last_of_run   <= 1'b1;
      error_flag    <= error_seen;
    end else if (cmd.emit_term) begin
      out_char      <= CH_NUL;
      is_terminator <= 1'b1;
      last_of_run   <= 1'b1;
      error_flag    <= error_seen;
    end else begin
      out_char      <= out_char;
      is_terminator <= is_terminator;
      last_of_run   <= last_of_run;
      error_flag    <= error_flag;
    end
  end

endmodule

FILE: sv/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer: accepts one word, then walks the stack one pop at a time.
// ----------------------------------------------------------------------------
module i2p_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2p_pkg::sts_t sts,
  output i2p_pkg::cmd_t cmd
);
  import i2p_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHAR,
    S_RD,
    S_DEC,
    S_TERM
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          unique case (sts.in_kind)
            KIND_LETTER: state_next = S_CHAR;
            KIND_LPAR:   cmd.push_in = 1'b1;
            KIND_SPACE:  state_next = S_IDLE;
            KIND_RPAR, KIND_OP, KIND_EOL: state_next = S_RD;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CHAR: begin
        if (sts.out_free) begin
          cmd.emit_char = 1'b1;
          state_next    = S_IDLE;
        end
      end
      // wait out the registered stack read
      S_RD: state_next = S_DEC;
      S_DEC: begin
        unique case (sts.kind)
          KIND_EOL: begin
            if (sts.count_zero) begin
              state_next = S_TERM;
            end else if (sts.out_free) begin
              cmd.emit_top = 1'b1;
              cmd.pop      = 1'b1;
              state_next   = S_RD;
            end
          end
          KIND_RPAR: begin
            if (sts.count_zero) begin
              cmd.set_err = 1'b1;
              state_next  = S_IDLE;
            end else if (sts.top_lpar) begin
              cmd.pop    = 1'b1;
              state_next = S_IDLE;
            end else if (sts.out_free) begin
              cmd.emit_top  = 1'b1;
              cmd.pop       = 1'b1;
              cmd.err_extra = sts.open_zero;
              cmd.top_last  = sts.open_zero ? sts.count_one : sts.below_lpar;
              if (sts.open_zero && sts.count_one) begin
                cmd.set_err = 1'b1;
                state_next  = S_IDLE;
              end else begin
                state_next = S_RD;
              end
            end
          end
          KIND_OP: begin
            if (sts.count_zero || sts.stop_top) begin
              cmd.push_op = 1'b1;
              state_next  = S_IDLE;
            end else if (sts.out_free) begin
              cmd.emit_top = 1'b1;
              cmd.pop      = 1'b1;
              cmd.top_last = sts.count_one | sts.stop_below;
              state_next   = S_RD;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_TERM: begin
        if (sts.out_free) begin
          cmd.emit_term = 1'b1;
          cmd.clear_eol = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: sv/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard conversion of an infix character stream to postfix.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------------------
//   input   | in_valid / in_ready  | in_char, end_of_line
//   output  | out_valid / out_ready| out_char, is_terminator, last_of_run,
//           |                      | error_flag
//
// A letter goes out from S_CHAR. A word that touches the stack (operator,
// ')', end of line) passes S_RD and S_DEC for each entry popped and sent out,
// to wait out the registered read of the stack memory; end of line then adds
// a terminator from S_TERM. Reset clears the stack count, the '(' count and
// the error flag. A stalled output holds the sequencer in place; one finished
// word can wait in the output register while the next stack read proceeds.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       is_terminator,
  output logic       last_of_run,
  output logic       error_flag
);
  import i2p_pkg::*;

  cmd_t cmd;
  sts_t sts;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2p_dpath #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .in_char       (in_char),
    .end_of_line   (end_of_line),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_char      (out_char),
    .is_terminator (is_terminator),
    .last_of_run   (last_of_run),
    .error_flag    (error_flag)
  );

  // a terminator always closes its run and carries a null character
  a_term_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_terminator |-> last_of_run && out_char == CH_NUL)
    else $error("terminator without last flag or with nonzero char");

  // popping a '(' means the open count cannot be zero
  a_lpar_count: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && sts.top_lpar |-> !sts.open_zero)
    else $error("'(' popped with zero open count");

  // never push and pop in one cycle
  a_push_pop: assert property (@(posedge clk) disable iff (rst)
    !((cmd.push_in || cmd.push_op) && cmd.pop))
    else $error("push and pop in the same cycle");

  // a new word is only loaded into the output while the slot is free
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_top || cmd.emit_char || cmd.emit_term) |-> (!out_valid || out_ready))
    else $error("output overwritten while stalled");

endmodule
